// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared constants, widths and types for the four-motor omni wheel mixer.
// ----------------------------------------------------------------------------
package owm_pkg;

   // angle and cosine formats
   localparam int ANGLE_BITS    = 12;
   localparam int COS_FRAC_BITS = 14;
   localparam int QUARTER_LEN   = 1 << (ANGLE_BITS - 2);
   localparam int EIGHTH_LEN    = 1 << (ANGLE_BITS - 3);
   localparam int ROM_ADDR_W    = ANGLE_BITS - 1;
   localparam int COS_W         = COS_FRAC_BITS + 1;

   // field widths
   localparam int SPEED_W = 8;
   localparam int HEAD_W  = 8;
   localparam int GAIN_W  = 4;
   localparam int LIMIT_W = 7;
   localparam int CMD_W   = 8;
   localparam int CENTER  = 127;

   // datapath widths
   localparam int ERR_W   = HEAD_W + 1;
   localparam int STEER_W = GAIN_W + ERR_W + 1;
   localparam int BASE_W  = SPEED_W + COS_W + 1;
   localparam int V_W     = STEER_W + COS_FRAC_BITS + 1;
   localparam int MAG_W   = V_W - COS_FRAC_BITS;
   localparam int PROD_W  = MAG_W + LIMIT_W;

   // pipeline layout: four front stages, one divider step per quotient bit, output
   localparam int DIV_STEPS    = LIMIT_W;
   localparam int FRONT_STAGES = 4;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;
   localparam int NUM_WHEELS   = 4;

   // register port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(2);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

   typedef enum logic {
      CSR_STEER_GAIN  = 1'b0,
      CSR_SPEED_LIMIT = 1'b1
   } csr_reg_type;

   // per-wheel side band through the divider
   typedef struct packed {
      logic neg;
      logic rescale;
   } scale_ctl_type;

endpackage

// ===== rtl/owm_ifs.sv =====
// ----------------------------------------------------------------------------
// owm request and response interfaces
// Valid/ready channels carrying the mixer request and the wheel commands.
// ----------------------------------------------------------------------------
interface owm_req_if;
   logic                            valid;
   logic                            ready;
   logic [owm_pkg::ANGLE_BITS-1:0]  travel_angle;
   logic [owm_pkg::SPEED_W-1:0]     travel_speed;
   logic [owm_pkg::HEAD_W-1:0]      heading_sample;

   modport source (output valid, travel_angle, travel_speed, heading_sample,
                   input ready);
   modport sink (input valid, travel_angle, travel_speed, heading_sample,
                 output ready);
endinterface

interface owm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [owm_pkg::CMD_W-1:0]  wheel0_cmd;
   logic [owm_pkg::CMD_W-1:0]  wheel1_cmd;
   logic [owm_pkg::CMD_W-1:0]  wheel2_cmd;
   logic [owm_pkg::CMD_W-1:0]  wheel3_cmd;

   modport source (output valid, wheel0_cmd, wheel1_cmd, wheel2_cmd, wheel3_cmd,
                   input ready);
   modport sink (input valid, wheel0_cmd, wheel1_cmd, wheel2_cmd, wheel3_cmd,
                 output ready);
endinterface

// ===== rtl/omni_wheel_mixer_four_motor_unit.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_mixer_four_motor_unit
// X-drive wheel mixer: travel angle and speed to four wheel speeds, heading
// correction from the gyro byte, proportional rescale to the speed limit.
//
//   port     direction   handshake       contents
//   req      in          valid/ready     travel_angle, travel_speed, heading_sample
//   rsp      out         valid/ready     wheel0_cmd .. wheel3_cmd
//   csr_*    in/out      apb write/read  steer_gain (0x0), speed_limit (0x4)
//
// One request per cycle is accepted unless a response stall fills the pipe;
// each response passes the four front stages and the seven-step divider lanes.
// Reset clears the stage valid bits and loads steer_gain 2, speed_limit 50.
// Every stage moves when the stage after it is empty or moving, so bubbles
// close up and a stalled response holds only the stages behind it that are full.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_four_motor_unit (
   input  logic                              clock,
   input  logic                              reset,
   owm_req_if.sink                           req,
   owm_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [owm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [owm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [owm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import owm_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   // configuration registers
   logic [GAIN_W-1:0]  gain_ff;
   logic [LIMIT_W-1:0] limit_ff;
   csr_reg_type        csr_sel;

   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_IDX_BIT]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_sel)
            CSR_STEER_GAIN:  gain_ff  <= csr_pwdata[GAIN_W-1:0];
            CSR_SPEED_LIMIT: limit_ff <= csr_pwdata[LIMIT_W-1:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_sel)
         CSR_STEER_GAIN:  csr_prdata = CSR_DATA_W'(gain_ff);
         CSR_SPEED_LIMIT: csr_prdata = CSR_DATA_W'(limit_ff);
      endcase
   end

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stg_en;

   always_comb begin
      stg_en[LAST] = !vld_ff[LAST] || rsp.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stg_en[k] = !vld_ff[k] || stg_en[k+1];
      end
      vld_in[0] = stg_en[0] ? req.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stg_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = stg_en[0];

   // stage 0: fold both angles into the quarter wave, steering error product
   function automatic logic [ROM_ADDR_W:0] cos_fold(input logic [ANGLE_BITS-1:0] t);
      logic [1:0]            quad;
      logic [ROM_ADDR_W-1:0] rx;
      logic [ROM_ADDR_W-1:0] rc;
      logic [ROM_ADDR_W:0]   res;
      quad = t[ANGLE_BITS-1 -: 2];
      rx   = {1'b0, t[ANGLE_BITS-3:0]};
      rc   = ROM_ADDR_W'(QUARTER_LEN) - rx;
      case (quad)
         2'd0:    res = {1'b0, rx};
         2'd1:    res = {1'b1, rc};
         2'd2:    res = {1'b1, rx};
         default: res = {1'b0, rc};
      endcase
      return res;
   endfunction

   logic [ANGLE_BITS-1:0]     ang_m;
   logic [ANGLE_BITS-1:0]     ang_p;
   logic [ROM_ADDR_W:0]       fold_m;
   logic [ROM_ADDR_W:0]       fold_p;
   logic signed [ERR_W-1:0]   head_err;
   logic signed [STEER_W-1:0] steer_in;

   always_comb begin
      ang_m    = req.travel_angle - ANGLE_BITS'(EIGHTH_LEN);
      ang_p    = req.travel_angle + ANGLE_BITS'(EIGHTH_LEN);
      fold_m   = cos_fold(ang_m);
      fold_p   = cos_fold(ang_p);
      head_err = $signed({1'b0, req.heading_sample}) - $signed(ERR_W'(CENTER));
      steer_in = $signed({1'b0, gain_ff}) * head_err;
   end

   logic [COS_W-1:0]          cos0;
   logic [COS_W-1:0]          cos1;
   logic                      cneg0_ff;
   logic                      cneg1_ff;
   logic [SPEED_W-1:0]        speed0_ff;
   logic signed [STEER_W-1:0] steer0_ff;

   owm_cos_rom u_cos_rom (
      .clock     (clock),
      .rd_en     (stg_en[0]),
      .addr_a    (fold_m[ROM_ADDR_W-1:0]),
      .addr_b    (fold_p[ROM_ADDR_W-1:0]),
      .rd_data_a (cos0),
      .rd_data_b (cos1)
   );

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         cneg0_ff  <= fold_m[ROM_ADDR_W];
         cneg1_ff  <= fold_p[ROM_ADDR_W];
         speed0_ff <= req.travel_speed;
         steer0_ff <= steer_in;
      end
   end

   // stage 1: speed times cosine for both wheel pairs
   logic [SPEED_W+COS_W-1:0]  bprod0;
   logic [SPEED_W+COS_W-1:0]  bprod1;
   logic signed [BASE_W-1:0]  base0_ff;
   logic signed [BASE_W-1:0]  base1_ff;
   logic signed [STEER_W-1:0] steer1_ff;

   assign bprod0 = (SPEED_W+COS_W)'(speed0_ff) * (SPEED_W+COS_W)'(cos0);
   assign bprod1 = (SPEED_W+COS_W)'(speed0_ff) * (SPEED_W+COS_W)'(cos1);

   always_ff @(posedge clock) begin
      if (stg_en[1]) begin
         base0_ff  <= cneg0_ff ? -$signed({1'b0, bprod0}) : $signed({1'b0, bprod0});
         base1_ff  <= cneg1_ff ? -$signed({1'b0, bprod1}) : $signed({1'b0, bprod1});
         steer1_ff <= steer0_ff;
      end
   end

   // stage 2: add or subtract the steering term, magnitude truncated toward zero
   logic signed [V_W-1:0] steer_sh;
   logic signed [V_W-1:0] wsum [NUM_WHEELS];
   logic [V_W-1:0]        wabs [NUM_WHEELS];
   logic [MAG_W-1:0]      mag2_ff [NUM_WHEELS];
   logic                  neg2_ff [NUM_WHEELS];

   always_comb begin
      steer_sh = V_W'(steer1_ff) <<< COS_FRAC_BITS;
      wsum[0]  = V_W'(base0_ff) + steer_sh;
      wsum[1]  = V_W'(base1_ff) + steer_sh;
      wsum[2]  = V_W'(base0_ff) - steer_sh;
      wsum[3]  = V_W'(base1_ff) - steer_sh;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         wabs[i] = wsum[i][V_W-1] ? V_W'(-wsum[i]) : V_W'(wsum[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            mag2_ff[i] <= wabs[i][V_W-1:COS_FRAC_BITS];
            neg2_ff[i] <= wsum[i][V_W-1];
         end
      end
   end

   // stage 3: largest magnitude, limit test, magnitude times limit
   logic [MAG_W-1:0]   mx_a;
   logic [MAG_W-1:0]   mx_b;
   logic [MAG_W-1:0]   mx_all;
   logic               over_lim;
   logic [PROD_W-1:0]  prod3_ff [NUM_WHEELS];
   logic [LIMIT_W-1:0] pass3_ff [NUM_WHEELS];
   scale_ctl_type      ctl3_ff  [NUM_WHEELS];
   logic [MAG_W-1:0]   mx3_ff;

   always_comb begin
      mx_a     = (mag2_ff[0] > mag2_ff[1]) ? mag2_ff[0] : mag2_ff[1];
      mx_b     = (mag2_ff[2] > mag2_ff[3]) ? mag2_ff[2] : mag2_ff[3];
      mx_all   = (mx_a > mx_b) ? mx_a : mx_b;
      over_lim = mx_all > MAG_W'(limit_ff);
   end

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         mx3_ff <= mx_all;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            prod3_ff[i]        <= PROD_W'(mag2_ff[i]) * PROD_W'(limit_ff);
            pass3_ff[i]        <= mag2_ff[i][LIMIT_W-1:0];
            ctl3_ff[i].neg     <= neg2_ff[i];
            ctl3_ff[i].rescale <= over_lim;
         end
      end
   end

   // stages 4 and up: divider lanes and output registers
   logic [CMD_W-1:0] wheel_cmd [NUM_WHEELS];

   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
      owm_wheel_scale u_scale (
         .clock    (clock),
         .stage_en (stg_en[LAST:FRONT_STAGES]),
         .dividend (prod3_ff[w]),
         .divisor  (mx3_ff),
         .mag_pass (pass3_ff[w]),
         .ctl      (ctl3_ff[w]),
         .cmd      (wheel_cmd[w])
      );
   end

   assign rsp.valid      = vld_ff[LAST];
   assign rsp.wheel0_cmd = wheel_cmd[0];
   assign rsp.wheel1_cmd = wheel_cmd[1];
   assign rsp.wheel2_cmd = wheel_cmd[2];
   assign rsp.wheel3_cmd = wheel_cmd[3];

   // an accepted request always occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // a new response only comes from the stage just before the output
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(vld_ff[LAST-1]))
      else $error("response appeared without a preceding stage");

   // scaled wheel bytes never leave the 0..254 range
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.wheel0_cmd != '1) && (rsp.wheel1_cmd != '1) &&
                    (rsp.wheel2_cmd != '1) && (rsp.wheel3_cmd != '1))
      else $error("wheel command out of range");

endmodule

// ===== rtl/owm_cos_rom.sv =====
// ----------------------------------------------------------------------------
// owm_cos_rom
// Quarter-wave cosine ROM, two registered read ports, Q1.COS_FRAC_BITS data.
// ----------------------------------------------------------------------------
module owm_cos_rom (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [owm_pkg::ROM_ADDR_W-1:0]   addr_a,
   input  logic [owm_pkg::ROM_ADDR_W-1:0]   addr_b,
   output logic [owm_pkg::COS_W-1:0]        rd_data_a,
   output logic [owm_pkg::COS_W-1:0]        rd_data_b
);
   import owm_pkg::*;

   typedef logic [COS_W-1:0] cos_table_type [QUARTER_LEN+1];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam int          RND_SHIFT   = 30 - COS_FRAC_BITS;

   // taylor series per entry, evaluated at elaboration
   function automatic cos_table_type cos_table_build();
      cos_table_type   tbl;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      longint          sum;
      for (int k = 0; k <= QUARTER_LEN; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) >> (ANGLE_BITS - 2);
         x2   = (x * x) >> 30;
         term = ONE_Q30;
         sum  = longint'(ONE_Q30);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (longint'(sum) + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
         if (r > (64'd1 << COS_FRAC_BITS)) begin
            r = 64'd1 << COS_FRAC_BITS;
         end
         tbl[k] = r[COS_W-1:0];
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = cos_table_build();

   logic [COS_W-1:0] rd_data_a_ff;
   logic [COS_W-1:0] rd_data_b_ff;

   // registered reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= COS_TABLE[addr_a];
         rd_data_b_ff <= COS_TABLE[addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/owm_wheel_scale.sv =====
// ----------------------------------------------------------------------------
// owm_wheel_scale
// One wheel lane: pipelined restoring divide (one quotient bit per stage),
// then sign restore and offset to the drive byte.
// ----------------------------------------------------------------------------
module owm_wheel_scale (
   input  logic                             clock,
   input  logic [owm_pkg::DIV_STEPS:0]      stage_en,
   input  logic [owm_pkg::PROD_W-1:0]       dividend,
   input  logic [owm_pkg::MAG_W-1:0]        divisor,
   input  logic [owm_pkg::LIMIT_W-1:0]      mag_pass,
   input  owm_pkg::scale_ctl_type           ctl,
   output logic [owm_pkg::CMD_W-1:0]        cmd
);
   import owm_pkg::*;

   logic [PROD_W-1:0]  rem_ff  [DIV_STEPS];
   logic [MAG_W-1:0]   dsr_ff  [DIV_STEPS];
   logic [LIMIT_W-1:0] quo_ff  [DIV_STEPS];
   logic [LIMIT_W-1:0] pass_ff [DIV_STEPS];
   scale_ctl_type      ctl_ff  [DIV_STEPS];
   logic [CMD_W-1:0]   cmd_ff;
   logic [LIMIT_W-1:0] mag_fin;
   logic [CMD_W-1:0]   cmd_in;

   // divider steps, most significant quotient bit first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [PROD_W-1:0]  rem_src;
      logic [MAG_W-1:0]   dsr_src;
      logic [LIMIT_W-1:0] quo_src;
      logic [LIMIT_W-1:0] pass_src;
      scale_ctl_type      ctl_src;
      logic [PROD_W-1:0]  trial;
      logic               ge;

      if (j == 0) begin : g_first
         assign rem_src  = dividend;
         assign dsr_src  = divisor;
         assign quo_src  = '0;
         assign pass_src = mag_pass;
         assign ctl_src  = ctl;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign dsr_src  = dsr_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign pass_src = pass_ff[j-1];
         assign ctl_src  = ctl_ff[j-1];
      end

      assign trial = PROD_W'(dsr_src) << (DIV_STEPS - 1 - j);
      assign ge    = (rem_src >= trial);

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= ge ? (rem_src - trial) : rem_src;
            dsr_ff[j]  <= dsr_src;
            quo_ff[j]  <= {quo_src[LIMIT_W-2:0], ge};
            pass_ff[j] <= pass_src;
            ctl_ff[j]  <= ctl_src;
         end
      end
   end

   // pick scaled or raw magnitude, restore sign, add the center offset
   always_comb begin
      mag_fin = ctl_ff[DIV_STEPS-1].rescale ? quo_ff[DIV_STEPS-1] : pass_ff[DIV_STEPS-1];
      if (ctl_ff[DIV_STEPS-1].neg) begin
         cmd_in = CMD_W'(CENTER) - CMD_W'(mag_fin);
      end else begin
         cmd_in = CMD_W'(CENTER) + CMD_W'(mag_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[DIV_STEPS]) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

// ===== sim/omni_wheel_mixer_four_motor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_mixer_four_motor_unit_tb
// Self-checking bench for the X-drive wheel mixer. A scoreboard class keeps
// its own cosine table and register copy, predicts the four wheel commands of
// every accepted request and checks the responses in order. Register settings
// change between phases while the pipeline is empty; both channel sides idle
// at random, and one long response stall backs the pipeline up.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_four_motor_unit_tb;
   import owm_pkg::*;

   localparam int IDLE_LIMIT       = 4000;
   localparam int LONG_HOLD        = 300;
   localparam int DRAIN_CYCLES     = NUM_STAGES + 4;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int SHOWN_FAILURES   = 10;
   localparam int ROUND_SHIFT      = 30 - COS_FRAC_BITS;

   typedef struct packed {
      logic [CMD_W-1:0] wheel0;
      logic [CMD_W-1:0] wheel1;
      logic [CMD_W-1:0] wheel2;
      logic [CMD_W-1:0] wheel3;
   } wheel_cmd_set_type;

   // wheel command predictor and in-order store of expected commands
   class wheel_mix_scoreboard;
      logic [GAIN_W-1:0]  steer_gain;
      logic [LIMIT_W-1:0] speed_limit;
      int                 cos_quarter[QUARTER_LEN+1];
      wheel_cmd_set_type  expected_wheels[$];
      int unsigned        requests;
      int unsigned        results;
      int unsigned        rescaled;
      int unsigned        failures;

      function new();
         steer_gain  = GAIN_RESET;
         speed_limit = LIMIT_RESET;
         requests    = 0;
         results     = 0;
         rescaled    = 0;
         failures    = 0;
         for (int k = 0; k <= QUARTER_LEN; k++) cos_quarter[k] = cos_entry(k);
      endfunction

      // quarter-wave cosine in Q1.14 from an eleven-term series in Q30
      function int cos_entry(int unsigned k);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint          acc;
         x    = (64'd1686629713 * k) >> (ANGLE_BITS - 2);
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(term);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         acc = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         if (acc > (longint'(1) << COS_FRAC_BITS)) acc = longint'(1) << COS_FRAC_BITS;
         return int'(acc);
      endfunction

      // full wave by quadrant symmetry
      function int wave_cos(logic [ANGLE_BITS-1:0] t);
         logic [1:0]  quad;
         int unsigned rem;
         quad = t[ANGLE_BITS-1 -: 2];
         rem  = t[ANGLE_BITS-3:0];
         case (quad)
            2'd0: return cos_quarter[rem];
            2'd1: return -cos_quarter[QUARTER_LEN - rem];
            2'd2: return -cos_quarter[rem];
            default: return cos_quarter[QUARTER_LEN - rem];
         endcase
      endfunction

      function wheel_cmd_set_type predict_wheels(logic [ANGLE_BITS-1:0] angle,
                                                 logic [SPEED_W-1:0] speed,
                                                 logic [HEAD_W-1:0] heading);
         longint                steer;
         longint                base0;
         longint                base1;
         longint                mx;
         longint                v[NUM_WHEELS];
         longint                mag[NUM_WHEELS];
         logic [CMD_W-1:0]      cmd[NUM_WHEELS];
         logic [ANGLE_BITS-1:0] ang_lo;
         logic [ANGLE_BITS-1:0] ang_hi;
         ang_lo = angle - ANGLE_BITS'(EIGHTH_LEN);
         ang_hi = angle + ANGLE_BITS'(EIGHTH_LEN);
         steer  = longint'(steer_gain) * (longint'(heading) - CENTER)
                  * (longint'(1) << COS_FRAC_BITS);
         base0  = longint'(speed) * wave_cos(ang_lo);
         base1  = longint'(speed) * wave_cos(ang_hi);
         v[0]   = base0 + steer;
         v[1]   = base1 + steer;
         v[2]   = base0 - steer;
         v[3]   = base1 - steer;
         // magnitudes truncate toward zero
         mx = 0;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            mag[i] = (v[i] < 0 ? -v[i] : v[i]) >>> COS_FRAC_BITS;
            if (mag[i] > mx) mx = mag[i];
         end
         // proportional rescale down to the limit
         if (mx > longint'(speed_limit)) begin
            rescaled++;
            for (int i = 0; i < NUM_WHEELS; i++)
               mag[i] = mag[i] * longint'(speed_limit) / mx;
         end
         // sign back on, a negative zero lands on center
         for (int i = 0; i < NUM_WHEELS; i++)
            cmd[i] = CMD_W'((v[i] < 0 ? -mag[i] : mag[i]) + CENTER);
         return {cmd[0], cmd[1], cmd[2], cmd[3]};
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= SHOWN_FAILURES) $display("ERROR: %s", msg);
      endfunction

      function void note_request(logic [ANGLE_BITS-1:0] angle, logic [SPEED_W-1:0] speed,
                                 logic [HEAD_W-1:0] heading);
         requests++;
         expected_wheels.push_back(predict_wheels(angle, speed, heading));
      endfunction

      function void check_wheels(wheel_cmd_set_type got);
         wheel_cmd_set_type want;
         results++;
         if (expected_wheels.size() == 0) begin
            flag($sformatf("response %0d %0d %0d %0d with no request outstanding",
                           got.wheel0, got.wheel1, got.wheel2, got.wheel3));
            return;
         end
         want = expected_wheels.pop_front();
         if (got.wheel0 !== want.wheel0 || got.wheel1 !== want.wheel1 ||
             got.wheel2 !== want.wheel2 || got.wheel3 !== want.wheel3)
            flag($sformatf("response %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           results, want.wheel0, want.wheel1, want.wheel2, want.wheel3,
                           got.wheel0, got.wheel1, got.wheel2, got.wheel3));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   owm_req_if req_ch();
   owm_rsp_if rsp_ch();

   wheel_mix_scoreboard sb = new();
   bit                  source_eager  = 1'b0;
   bit                  sink_eager    = 1'b0;
   bit                  long_hold_due = 1'b0;
   int unsigned         idle_cycles   = 0;
   int unsigned         settings_used = 1;

   omni_wheel_mixer_four_motor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // request and response monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.note_request(req_ch.travel_angle, req_ch.travel_speed, req_ch.heading_sample);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_wheels({rsp_ch.wheel0_cmd, rsp_ch.wheel1_cmd,
                             rsp_ch.wheel2_cmd, rsp_ch.wheel3_cmd});
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_psel === 1'b1 && csr_penable === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("omni_wheel_mixer_four_motor_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random ready gaps, one long hold on request
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = sink_eager ? 0 : $urandom_range(0, 3);
         if (long_hold_due) begin
            gap           = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
      end
   end

   // offer one request after a random gap, return at its acceptance edge
   task automatic send_request(input logic [ANGLE_BITS-1:0] angle,
                               input logic [SPEED_W-1:0] speed,
                               input logic [HEAD_W-1:0] heading);
      int gap;
      gap = source_eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.travel_angle   <= angle;
      req_ch.travel_speed   <= speed;
      req_ch.heading_sample <= heading;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // register write followed by a read-back of the same register
   task automatic write_register(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(which) << CSR_IDX_BIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (which)
         CSR_STEER_GAIN: begin
            sb.steer_gain = value[GAIN_W-1:0];
            if (readback[GAIN_W-1:0] !== value[GAIN_W-1:0])
               sb.flag($sformatf("steer_gain read %0d after writing %0d",
                                 readback[GAIN_W-1:0], value[GAIN_W-1:0]));
         end
         default: begin
            sb.speed_limit = value[LIMIT_W-1:0];
            if (readback[LIMIT_W-1:0] !== value[LIMIT_W-1:0])
               sb.flag($sformatf("speed_limit read %0d after writing %0d",
                                 readback[LIMIT_W-1:0], value[LIMIT_W-1:0]));
         end
      endcase
   endtask

   // stop offering and wait for every expected response, then settle
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_wheels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register setting followed by shaped random requests
   task automatic run_phase(input logic [GAIN_W-1:0] gain, input logic [LIMIT_W-1:0] limit,
                            input bit hold);
      int                    kind;
      logic [ANGLE_BITS-1:0] angle;
      logic [SPEED_W-1:0]    speed;
      logic [HEAD_W-1:0]     heading;
      drain_pipeline();
      write_register(CSR_STEER_GAIN, CSR_DATA_W'(gain));
      write_register(CSR_SPEED_LIMIT, CSR_DATA_W'(limit));
      settings_used++;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         // stretches with and without idling on each side
         if (i % 32 == 0) begin
            source_eager = ($urandom_range(0, 3) == 0);
            sink_eager   = ($urandom_range(0, 3) == 0);
         end
         if (hold && i == 40) long_hold_due = 1'b1;
         kind    = $urandom_range(0, 7);
         angle   = ANGLE_BITS'($urandom);
         speed   = SPEED_W'($urandom);
         heading = HEAD_W'($urandom);
         case (kind)
            // heading close to on target
            0: heading = HEAD_W'(CENTER - 3 + int'($urandom_range(0, 6)));
            // slow travel, mostly below the limit
            1: speed = SPEED_W'($urandom_range(0, 8));
            // around the octant boundaries of the angle
            2: angle = ANGLE_BITS'(EIGHTH_LEN * int'($urandom_range(0, 7))
                                   + int'($urandom_range(0, 2)) - 1);
            default: ;
         endcase
         send_request(angle, speed, heading);
      end
   endtask

   // main sequence
   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.travel_angle   <= '0;
      req_ch.travel_speed   <= '0;
      req_ch.heading_sample <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests under the reset register values
      send_request(12'd0,    8'd255, 8'd127);
      send_request(12'd4095, 8'd255, 8'd127);
      send_request(12'd512,  8'd255, 8'd127);
      send_request(12'd1024, 8'd255, 8'd127);
      send_request(12'd1536, 8'd255, 8'd127);
      send_request(12'd2048, 8'd255, 8'd127);
      send_request(12'd2560, 8'd255, 8'd127);
      send_request(12'd3072, 8'd255, 8'd127);
      send_request(12'd3584, 8'd255, 8'd127);
      send_request(12'd0,    8'd255, 8'd0);
      send_request(12'd0,    8'd255, 8'd255);
      send_request(12'd1024, 8'd0,   8'd0);
      send_request(12'd1024, 8'd0,   8'd255);
      send_request(12'd0,    8'd40,  8'd127);
      send_request(12'd512,  8'd30,  8'd130);
      // tiny negative sums that truncate to zero
      send_request(12'd1537, 8'd1,   8'd127);
      send_request(12'd2559, 8'd1,   8'd127);
      send_request(12'd0,    8'd0,   8'd128);
      send_request(12'd0,    8'd0,   8'd126);
      send_request(12'd2047, 8'd128, 8'd64);
      send_request(12'd1,    8'd200, 8'd200);

      // register settings, extremes first
      run_phase(4'd0,  7'd127, 1'b0);
      run_phase(4'd15, 7'd1,   1'b0);
      run_phase(4'd15, 7'd127, 1'b1);
      run_phase(4'd0,  7'd0,   1'b0);
      run_phase(4'd9,  7'd64,  1'b0);
      run_phase(4'd15, 7'd0,   1'b0);
      run_phase(GAIN_W'($urandom), LIMIT_W'($urandom_range(1, 127)), 1'b0);
      run_phase(GAIN_W'($urandom), LIMIT_W'($urandom_range(1, 127)), 1'b0);
      drain_pipeline();

      $display("covered %0d requests over %0d register settings, %0d rescaled to the limit",
               sb.requests, settings_used, sb.rescaled);
      $display("checked %0d responses, %0d failures", sb.results, sb.failures);
      if (sb.failures == 0 && sb.expected_wheels.size() == 0) begin
         $display("omni_wheel_mixer_four_motor_unit verification clean");
      end else begin
         $display("omni_wheel_mixer_four_motor_unit verification failed");
      end
      $finish;
   end

endmodule
